[src/gfgrd_pkg.sv]
// Package: phase codes, result kinds and opcode constants for the GF glyph decoder.
`timescale 1ns / 1ps
package gfgrd_pkg;

  typedef enum logic [8:0] {
    PH_SEEK      = 9'b000000001,
    PH_RAST      = 9'b000000010,
    PH_SEEK_ARG  = 9'b000000100,
    PH_RAST_ARG  = 9'b000001000,
    PH_SEEK_DROP = 9'b000010000,
    PH_RAST_DROP = 9'b000100000,
    PH_BOC       = 9'b001000000,
    PH_BOC1      = 9'b010000000,
    PH_PRE_VER   = 9'b100000000
  } phase_t;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_RUN    = 3'd1;
  localparam logic [2:0] KIND_EOC    = 3'd2;
  localparam logic [2:0] KIND_POST   = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [7:0] OP_BOC     = 8'd67;
  localparam logic [7:0] OP_BOC1    = 8'd68;
  localparam logic [7:0] OP_EOC     = 8'd69;
  localparam logic [7:0] OP_SKIP0   = 8'd70;
  localparam logic [7:0] OP_YYY     = 8'd243;
  localparam logic [7:0] OP_NOOP    = 8'd244;
  localparam logic [7:0] OP_PRE     = 8'd247;
  localparam logic [7:0] OP_POST    = 8'd248;
  localparam logic [7:0] GF_ID      = 8'd131;
  localparam logic [7:0] CODE_MASK  = 8'o377;
  localparam logic [2:0] INDEX_MASK = 3'o7;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] xoff;
    logic [31:0] yoff;
    logic [23:0] row;
    logic [23:0] col;
    logic [23:0] len;
  } result_t;

endpackage

[src/gfgrd_parser.sv]
// Parser: command state machine and raster position, one byte per cycle while step is high.
`timescale 1ns / 1ps
module gfgrd_parser #(
  parameter int COORD_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  output gfgrd_pkg::result_t  res
);

  localparam logic [COORD_BITS-1:0] CMAX = '1;

  gfgrd_pkg::phase_t phase, phase_next;
  logic [7:0]  held_opcode, held_opcode_next;
  logic [31:0] operand_accum, operand_accum_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [2:0]  param_index, param_index_next;
  logic [7:0]  code_hold, code_hold_next;
  logic [31:0] min_col, min_col_next, max_col, max_col_next, min_row, min_row_next;
  logic [COORD_BITS-1:0] cur_column, cur_column_next, cur_row, cur_row_next;
  logic ink_black, ink_black_next;

  logic [31:0] acc_shift;
  logic        last_byte;

  function automatic logic [23:0] cap24(input logic [31:0] v);
    cap24 = (v > 32'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                    input logic [32:0] b);
    logic [33:0] s;
    s = {{(34-COORD_BITS){1'b0}}, a} + {1'b0, b};
    sat_add = (s > {{(34-COORD_BITS){1'b0}}, CMAX}) ? CMAX : s[COORD_BITS-1:0];
  endfunction

  always_comb begin
    phase_next = phase;
    held_opcode_next = held_opcode;
    operand_accum_next = operand_accum;
    bytes_remaining_next = bytes_remaining;
    param_index_next = param_index;
    code_hold_next = code_hold;
    min_col_next = min_col;
    max_col_next = max_col;
    min_row_next = min_row;
    cur_column_next = cur_column;
    cur_row_next = cur_row;
    ink_black_next = ink_black;
    res = '0;
    acc_shift = {operand_accum[23:0], in_byte};
    last_byte = (bytes_remaining <= 32'd1);

    // shared actions expressed inline via small helper blocks
    case (phase)
      gfgrd_pkg::PH_RAST: begin
        if (in_byte <= 8'd63) begin
          if (in_byte != 8'd0 && ink_black) begin
            res.valid = 1'b1;
            res.kind = gfgrd_pkg::KIND_RUN;
            res.row = cap24(32'(cur_row));
            res.col = cap24(32'(cur_column));
            res.len = cap24({24'd0, in_byte});
          end
          if (in_byte != 8'd0) cur_column_next = sat_add(cur_column, {25'd0, in_byte});
          ink_black_next = ~ink_black;
        end else if (in_byte <= 8'd66 || (in_byte >= 8'd71 && in_byte <= 8'd73)
                     || (in_byte >= 8'd239 && in_byte <= 8'd242)) begin
          held_opcode_next = in_byte;
          operand_accum_next = '0;
          bytes_remaining_next = (in_byte <= 8'd66) ? 32'(in_byte - 8'd63) :
                                 (in_byte <= 8'd73) ? 32'(in_byte - 8'd70) :
                                 32'(in_byte - 8'd238);
          phase_next = gfgrd_pkg::PH_RAST_ARG;
        end else if (in_byte == gfgrd_pkg::OP_EOC) begin
          phase_next = gfgrd_pkg::PH_SEEK;
          res.valid = 1'b1;
          res.kind = gfgrd_pkg::KIND_EOC;
        end else if (in_byte == gfgrd_pkg::OP_SKIP0) begin
          cur_row_next = sat_add(cur_row, 33'd1);
          cur_column_next = '0;
          ink_black_next = 1'b0;
        end else if (in_byte >= 8'd74 && in_byte <= 8'd238) begin
          // new_row: next row, skip the column offset in white, then paint black
          cur_row_next = sat_add(cur_row, 33'd1);
          cur_column_next = sat_add('0, {25'd0, in_byte - 8'd74});
          ink_black_next = 1'b1;
        end else if (in_byte == gfgrd_pkg::OP_YYY) begin
          bytes_remaining_next = 32'd4;
          phase_next = gfgrd_pkg::PH_RAST_DROP;
        end else if (in_byte == gfgrd_pkg::OP_NOOP) begin
          phase_next = gfgrd_pkg::PH_RAST;
        end else begin
          phase_next = gfgrd_pkg::PH_SEEK;
          res.valid = 1'b1;
          res.kind = gfgrd_pkg::KIND_ERROR;
        end
      end
      gfgrd_pkg::PH_SEEK_ARG, gfgrd_pkg::PH_RAST_ARG: begin
        operand_accum_next = acc_shift;
        if (!last_byte) begin
          bytes_remaining_next = bytes_remaining - 32'd1;
        end else begin
          bytes_remaining_next = acc_shift;
          if (phase == gfgrd_pkg::PH_SEEK_ARG) begin
            phase_next = (acc_shift != 0) ? gfgrd_pkg::PH_SEEK_DROP : gfgrd_pkg::PH_SEEK;
          end else if (held_opcode >= 8'd64 && held_opcode <= 8'd66) begin
            bytes_remaining_next = '0;
            phase_next = gfgrd_pkg::PH_RAST;
            if (acc_shift != 0 && ink_black) begin
              res.valid = 1'b1;
              res.kind = gfgrd_pkg::KIND_RUN;
              res.row = cap24(32'(cur_row));
              res.col = cap24(32'(cur_column));
              res.len = cap24(acc_shift);
            end
            if (acc_shift != 0) cur_column_next = sat_add(cur_column, {1'b0, acc_shift});
            ink_black_next = ~ink_black;
          end else if (held_opcode >= 8'd71 && held_opcode <= 8'd73) begin
            bytes_remaining_next = '0;
            phase_next = gfgrd_pkg::PH_RAST;
            cur_row_next = sat_add(cur_row, {1'b0, acc_shift} + 33'd1);
            cur_column_next = '0;
            ink_black_next = 1'b0;
          end else begin
            phase_next = (acc_shift != 0) ? gfgrd_pkg::PH_RAST_DROP : gfgrd_pkg::PH_RAST;
          end
        end
      end
      gfgrd_pkg::PH_SEEK_DROP, gfgrd_pkg::PH_RAST_DROP: begin
        if (!last_byte) begin
          bytes_remaining_next = bytes_remaining - 32'd1;
        end else begin
          bytes_remaining_next = '0;
          phase_next = (phase == gfgrd_pkg::PH_SEEK_DROP) ? gfgrd_pkg::PH_SEEK
                                                           : gfgrd_pkg::PH_RAST;
        end
      end
      gfgrd_pkg::PH_BOC: begin
        operand_accum_next = acc_shift;
        if (!last_byte) begin
          bytes_remaining_next = bytes_remaining - 32'd1;
        end else begin
          param_index_next = (param_index + 3'd1) & gfgrd_pkg::INDEX_MASK;
          operand_accum_next = '0;
          bytes_remaining_next = 32'd4;
          case (param_index)
            3'd0: code_hold_next = acc_shift[7:0] & gfgrd_pkg::CODE_MASK;
            3'd1: ;
            3'd2: min_col_next = acc_shift;
            3'd3: max_col_next = acc_shift;
            3'd4: min_row_next = acc_shift;
            default: begin
              res.valid = 1'b1;
              res.kind = gfgrd_pkg::KIND_HEADER;
              res.code = code_hold;
              res.width = max_col - min_col + 32'd1;
              res.height = acc_shift - min_row + 32'd1;
              res.xoff = 32'd0 - min_col;
              res.yoff = acc_shift;
              phase_next = gfgrd_pkg::PH_RAST;
              cur_column_next = '0;
              cur_row_next = '0;
              ink_black_next = 1'b0;
            end
          endcase
        end
      end
      gfgrd_pkg::PH_BOC1: begin
        param_index_next = (param_index + 3'd1) & gfgrd_pkg::INDEX_MASK;
        case (param_index)
          3'd0: code_hold_next = in_byte;
          3'd1: min_col_next = {24'd0, in_byte};
          3'd2: begin
            max_col_next = {24'd0, in_byte};
            min_col_next = {24'd0, in_byte} - min_col;
          end
          3'd3: min_row_next = {24'd0, in_byte};
          default: begin
            min_row_next = {24'd0, in_byte} - min_row;
            res.valid = 1'b1;
            res.kind = gfgrd_pkg::KIND_HEADER;
            res.code = code_hold;
            res.width = max_col - min_col + 32'd1;
            res.height = {24'd0, in_byte} - ({24'd0, in_byte} - min_row) + 32'd1;
            res.xoff = 32'd0 - min_col;
            res.yoff = {24'd0, in_byte};
            phase_next = gfgrd_pkg::PH_RAST;
            cur_column_next = '0;
            cur_row_next = '0;
            ink_black_next = 1'b0;
          end
        endcase
      end
      gfgrd_pkg::PH_PRE_VER: begin
        if (in_byte != gfgrd_pkg::GF_ID) begin
          phase_next = gfgrd_pkg::PH_SEEK;
          res.valid = 1'b1;
          res.kind = gfgrd_pkg::KIND_ERROR;
        end else begin
          held_opcode_next = gfgrd_pkg::OP_PRE;
          operand_accum_next = '0;
          bytes_remaining_next = 32'd1;
          phase_next = gfgrd_pkg::PH_SEEK_ARG;
        end
      end
      default: begin
        phase_next = gfgrd_pkg::PH_SEEK;
        if (in_byte >= 8'd64 && in_byte <= 8'd66) begin
          bytes_remaining_next = 32'(in_byte - 8'd63);
          phase_next = gfgrd_pkg::PH_SEEK_DROP;
        end else if (in_byte >= 8'd71 && in_byte <= 8'd73) begin
          bytes_remaining_next = 32'(in_byte - 8'd70);
          phase_next = gfgrd_pkg::PH_SEEK_DROP;
        end else if (in_byte == gfgrd_pkg::OP_YYY) begin
          bytes_remaining_next = 32'd4;
          phase_next = gfgrd_pkg::PH_SEEK_DROP;
        end else if (in_byte == gfgrd_pkg::OP_BOC || in_byte == gfgrd_pkg::OP_BOC1) begin
          param_index_next = '0;
          held_opcode_next = in_byte;
          operand_accum_next = '0;
          bytes_remaining_next = (in_byte == gfgrd_pkg::OP_BOC) ? 32'd4 : 32'd1;
          phase_next = (in_byte == gfgrd_pkg::OP_BOC) ? gfgrd_pkg::PH_BOC
                                                       : gfgrd_pkg::PH_BOC1;
        end else if (in_byte >= 8'd239 && in_byte <= 8'd242) begin
          held_opcode_next = in_byte;
          operand_accum_next = '0;
          bytes_remaining_next = 32'(in_byte - 8'd238);
          phase_next = gfgrd_pkg::PH_SEEK_ARG;
        end else if (in_byte == gfgrd_pkg::OP_PRE) begin
          held_opcode_next = in_byte;
          phase_next = gfgrd_pkg::PH_PRE_VER;
        end else if (in_byte == gfgrd_pkg::OP_POST) begin
          res.valid = 1'b1;
          res.kind = gfgrd_pkg::KIND_POST;
        end else if (in_byte == 8'd245 || in_byte == 8'd246 || in_byte >= 8'd249) begin
          res.valid = 1'b1;
          res.kind = gfgrd_pkg::KIND_ERROR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= gfgrd_pkg::PH_SEEK;
      held_opcode <= '0;
      operand_accum <= '0;
      bytes_remaining <= '0;
      param_index <= '0;
      code_hold <= '0;
      min_col <= '0;
      max_col <= '0;
      min_row <= '0;
      cur_column <= '0;
      cur_row <= '0;
      ink_black <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      held_opcode <= held_opcode_next;
      operand_accum <= operand_accum_next;
      bytes_remaining <= bytes_remaining_next;
      param_index <= param_index_next;
      code_hold <= code_hold_next;
      min_col <= min_col_next;
      max_col <= max_col_next;
      min_row <= min_row_next;
      cur_column <= cur_column_next;
      cur_row <= cur_row_next;
      ink_black <= ink_black_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
  a_boc_idx: assert property (@(posedge clk) disable iff (rst)
    (phase == gfgrd_pkg::PH_BOC1) |-> (param_index <= 3'd4))
    else $error("boc1 index out of range");
  a_run_ink: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.kind == gfgrd_pkg::KIND_RUN) |-> ink_black)
    else $error("run emitted on white ink");

endmodule

[src/gf_glyph_raster_decoder_unit.sv]
// Top level: GF character byte decoder with registered result stage.
`timescale 1ns / 1ps
// GF glyph raster decoder.
// Input channel: in_valid/in_ready carry one byte of a GF command stream per
// request. Output channel: out_valid/out_ready carry one result request:
// character header, black run (row, column, length), end of char, postamble
// or format error. Fields that do not belong to a result's kind read zero.
// Each byte is decoded in the cycle it is accepted; its result, if any,
// appears in the output register on the next cycle.
// Throughput: one byte per cycle. in_ready is high whenever the output
// register is empty or is being drained in the same cycle, so a stalled
// receiver only holds the input once a result is waiting.
// While a result waits, every byte is held, including bytes that would
// produce no result.
// Reset (rst, synchronous) returns the parser to seeking a character start
// and empties the output register.
// COORD_BITS sets the width of the internal row and column counters, which
// saturate at their maximum; run outputs saturate at 24 bits.
module gf_glyph_raster_decoder_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [7:0]         char_code,
  output logic signed [31:0] glyph_width,
  output logic signed [31:0] glyph_height,
  output logic signed [31:0] x_offset,
  output logic signed [31:0] y_offset,
  output logic [23:0]        run_row,
  output logic [23:0]        run_column,
  output logic [23:0]        run_length
);

  gfgrd_pkg::result_t res, held;
  logic step;

  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;

  gfgrd_parser #(.COORD_BITS(COORD_BITS)) u_parser (
    .clk(clk), .rst(rst), .step(step), .in_byte(in_byte), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) held <= res;
  end

  assign out_kind = held.kind;
  assign char_code = held.code;
  assign glyph_width = held.width;
  assign glyph_height = held.height;
  assign x_offset = held.xoff;
  assign y_offset = held.yoff;
  assign run_row = held.row;
  assign run_column = held.col;
  assign run_length = held.len;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(held)))
    else $error("result lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result blocked");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind <= gfgrd_pkg::KIND_ERROR))
    else $error("bad result kind");

endmodule
